### rtl/tkcr_pkg.sv
// Shared types and constants of the top-k cost ranked list unit.
package tkcr_pkg;

  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned CostW         = 32;
  localparam int unsigned TagW          = 8;
  localparam int unsigned CfgW          = 6;
  localparam int unsigned TrimW         = 6;
  localparam int unsigned PosW          = 5;
  localparam int unsigned CountOutW     = 6;
  localparam logic [CfgW-1:0] CapacityReset = 6'd32;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdTrim   = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StEvict,
    StShift,
    StFinish
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_flags;
    logic mem_we;
    logic wr_new;
    logic cnt_trim;
    logic ev_capture;
    logic load_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_trim;
    logic gt;
    logic trim_ok;
    logic out_free;
  } sts_t;

endpackage

### rtl/top_k_cost_ranked_list_unit.sv
// Top level of the top-k cost ranked list unit.
// The unit keeps a list of tags sorted by descending signed cost, up to the
// configured capacity. An input transfer carries a command (insert or trim),
// a cost, a tag and a trim count; every input transfer yields exactly one
// output transfer with the outcome, the entry count and the best entry.
// The capacity register is written through the cfg channel, which is always
// ready; write it only while no item is in flight.
// An insert is registered at the input transfer and passes a setup step, then
// scans from rank 0 until it finds its rank, reads the dropped entry if one
// goes, shifts the lower entries down one per cycle and writes the new entry.
// A trim goes from setup straight to loading the result. The entry memory has
// one read and one write port, each used once per cycle.
// The output register decouples the sides: the next item is accepted while
// a result still waits, and processing holds in its last step until the
// receiver takes the previous result. Reset empties the list and sets the
// capacity to 32; entry memory contents are not cleared.
module top_k_cost_ranked_list_unit #(
  parameter int unsigned MAX_ENTRIES = tkcr_pkg::MaxEntriesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tkcr_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [tkcr_pkg::CostW-1:0] cost_i,
  input  logic [tkcr_pkg::TagW-1:0]         tag_i,
  input  logic [tkcr_pkg::TrimW-1:0]        trim_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic [tkcr_pkg::PosW-1:0]         position_o,
  output logic                              evicted_valid_o,
  output logic [tkcr_pkg::TagW-1:0]         evicted_tag_o,
  output logic [tkcr_pkg::CountOutW-1:0]    entry_count_o,
  output logic                              best_valid_o,
  output logic signed [tkcr_pkg::CostW-1:0] best_cost_o,
  output logic [tkcr_pkg::TagW-1:0]         best_tag_o
);
  import tkcr_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  ctl_t            ctl;
  sts_t            sts;
  logic [CntW-1:0] count;
  logic [CntW-1:0] cap;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;

  assign cfg_ready_o = 1'b1;

  tkcr_ctrl #(
    .MaxEntries (MAX_ENTRIES),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .count_i    (count),
    .cap_i      (cap),
    .ctl_o      (ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  tkcr_dpath #(
    .MaxEntries (MAX_ENTRIES),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .cost_i          (cost_i),
    .tag_i           (tag_i),
    .trim_count_i    (trim_count_i),
    .ctl_i           (ctl),
    .rd_addr_i       (rd_addr),
    .wr_addr_i       (wr_addr),
    .sts_o           (sts),
    .count_o         (count),
    .cap_o           (cap),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .accepted_o      (accepted_o),
    .position_o      (position_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_tag_o   (evicted_tag_o),
    .entry_count_o   (entry_count_o),
    .best_valid_o    (best_valid_o),
    .best_cost_o     (best_cost_o),
    .best_tag_o      (best_tag_o)
  );

endmodule

### rtl/tkcr_ctrl.sv
// Sequencer of the ranked list: scan for the insert rank, evict, shift and finish; a trim goes straight to finish.
module tkcr_ctrl #(
  parameter int unsigned MaxEntries = tkcr_pkg::MaxEntriesDef,
  parameter int unsigned IdxW       = $clog2(MaxEntries),
  parameter int unsigned CntW       = $clog2(MaxEntries + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tkcr_pkg::sts_t    sts_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [CntW-1:0]   cap_i,
  output tkcr_pkg::ctl_t    ctl_o,
  output logic [IdxW-1:0]   rd_addr_o,
  output logic [IdxW-1:0]   wr_addr_o
);
  import tkcr_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] place_q, place_d;
  logic [CntW-1:0] rd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      place_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      place_q <= place_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    place_d    = place_q;
    rd_idx     = idx_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d = StStart;
        end
      end
      StStart: begin
        ctl_o.clr_flags = 1'b1;
        if (sts_i.is_trim) begin
          ctl_o.cnt_trim = sts_i.trim_ok;
          state_d = StFinish;
        end else if (count_i == '0) begin
          place_d = '0;
          idx_d   = '0;
          state_d = StShift;
        end else begin
          idx_d   = '0;
          rd_idx  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        // The read data here always belongs to the entry at idx_q.
        if (sts_i.gt) begin
          place_d = idx_q;
          if (count_i >= cap_i) begin
            rd_idx  = count_i - CntW'(1);
            state_d = StEvict;
          end else begin
            idx_d   = count_i;
            rd_idx  = count_i - CntW'(1);
            state_d = StShift;
          end
        end else if (idx_q == count_i - CntW'(1)) begin
          place_d = count_i;
          if (count_i < cap_i) begin
            idx_d   = count_i;
            state_d = StShift;
          end else begin
            state_d = StFinish;
          end
        end else begin
          idx_d  = idx_q + CntW'(1);
          rd_idx = idx_q + CntW'(1);
        end
      end
      StEvict: begin
        ctl_o.ev_capture = 1'b1;
        idx_d   = count_i - CntW'(1);
        rd_idx  = count_i - CntW'(2);
        state_d = StShift;
      end
      StShift: begin
        // Each cycle moves the entry one rank down, reading ahead by one.
        ctl_o.mem_we = 1'b1;
        if (idx_q == place_q) begin
          ctl_o.wr_new = 1'b1;
          state_d = StFinish;
        end else begin
          idx_d  = idx_q - CntW'(1);
          rd_idx = idx_q - CntW'(2);
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign rd_addr_o = rd_idx[IdxW-1:0];
  assign wr_addr_o = idx_q[IdxW-1:0];

endmodule

### rtl/tkcr_dpath.sv
// Datapath of the ranked list: entry memory, count, best entry and result register.
module tkcr_dpath #(
  parameter int unsigned MaxEntries = tkcr_pkg::MaxEntriesDef,
  parameter int unsigned IdxW       = $clog2(MaxEntries),
  parameter int unsigned CntW       = $clog2(MaxEntries + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [tkcr_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              command_i,
  input  logic signed [tkcr_pkg::CostW-1:0] cost_i,
  input  logic [tkcr_pkg::TagW-1:0]         tag_i,
  input  logic [tkcr_pkg::TrimW-1:0]        trim_count_i,
  input  tkcr_pkg::ctl_t                    ctl_i,
  input  logic [IdxW-1:0]                   rd_addr_i,
  input  logic [IdxW-1:0]                   wr_addr_i,
  output tkcr_pkg::sts_t                    sts_o,
  output logic [CntW-1:0]                   count_o,
  output logic [CntW-1:0]                   cap_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              accepted_o,
  output logic [tkcr_pkg::PosW-1:0]         position_o,
  output logic                              evicted_valid_o,
  output logic [tkcr_pkg::TagW-1:0]         evicted_tag_o,
  output logic [tkcr_pkg::CountOutW-1:0]    entry_count_o,
  output logic                              best_valid_o,
  output logic signed [tkcr_pkg::CostW-1:0] best_cost_o,
  output logic [tkcr_pkg::TagW-1:0]         best_tag_o
);
  import tkcr_pkg::*;

  localparam int unsigned CmpW = (CntW > TrimW) ? CntW : TrimW;
  localparam int unsigned CapCmpW = (CntW > CfgW) ? CntW : CfgW;

  logic signed [CostW-1:0] cost_mem [MaxEntries];
  logic [TagW-1:0]         tag_mem  [MaxEntries];

  logic [CfgW-1:0]         capacity_q;
  logic [CntW-1:0]         count_q;
  logic                    cmd_q;
  logic signed [CostW-1:0] cost_q;
  logic [TagW-1:0]         tag_q;
  logic [TrimW-1:0]        trim_q;
  logic signed [CostW-1:0] rd_cost_q;
  logic [TagW-1:0]         rd_tag_q;
  logic signed [CostW-1:0] best_cost_q;
  logic [TagW-1:0]         best_tag_q;
  logic                    acc_q;
  logic [IdxW-1:0]         pos_q;
  logic                    ev_valid_q;
  logic [TagW-1:0]         ev_tag_q;
  logic                    out_valid_q;

  logic signed [CostW-1:0] wr_cost;
  logic [TagW-1:0]         wr_tag;
  logic [CntW-1:0]         cap_eff;

  assign wr_cost = ctl_i.wr_new ? cost_q : rd_cost_q;
  assign wr_tag  = ctl_i.wr_new ? tag_q  : rd_tag_q;

  // A capacity of zero acts as one, and any capacity above the list size as the list size.
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = CntW'(1);
    end else if (CapCmpW'(capacity_q) > CapCmpW'(MaxEntries)) begin
      cap_eff = CntW'(MaxEntries);
    end else begin
      cap_eff = CntW'(capacity_q);
    end
  end

  assign cap_o   = cap_eff;
  assign count_o = count_q;

  assign sts_o.is_trim  = (cmd_q == CmdTrim);
  assign sts_o.gt       = (cost_q > rd_cost_q);
  assign sts_o.trim_ok  = (CmpW'(count_q) > CmpW'(trim_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      cost_mem[wr_addr_i] <= wr_cost;
      tag_mem[wr_addr_i]  <= wr_tag;
    end
    rd_cost_q <= cost_mem[rd_addr_i];
    rd_tag_q  <= tag_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapacityReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      if (ctl_i.cnt_trim) begin
        count_q <= count_q - CntW'(trim_q);
      end else if (ctl_i.wr_new && !ev_valid_q) begin
        count_q <= count_q + CntW'(1);
      end
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q  <= command_i;
      cost_q <= cost_i;
      tag_q  <= tag_i;
      trim_q <= trim_count_i;
    end
    if (ctl_i.clr_flags) begin
      acc_q      <= 1'b0;
      pos_q      <= '0;
      ev_valid_q <= 1'b0;
      ev_tag_q   <= '0;
    end
    if (ctl_i.ev_capture) begin
      ev_valid_q <= 1'b1;
      ev_tag_q   <= rd_tag_q;
    end
    if (ctl_i.wr_new) begin
      acc_q <= 1'b1;
      pos_q <= wr_addr_i;
    end
    // Rank 0 is mirrored in registers so the result needs no extra read.
    if (ctl_i.mem_we && wr_addr_i == '0) begin
      best_cost_q <= wr_cost;
      best_tag_q  <= wr_tag;
    end
    if (ctl_i.load_out) begin
      accepted_o      <= acc_q;
      position_o      <= PosW'(pos_q);
      evicted_valid_o <= ev_valid_q;
      evicted_tag_o   <= ev_tag_q;
      entry_count_o   <= CountOutW'(count_q);
      best_valid_o    <= (count_q != '0);
      best_cost_o     <= (count_q != '0) ? best_cost_q : '0;
      best_tag_o      <= (count_q != '0) ? best_tag_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### bench/ranked_list_bench_pkg.sv
`timescale 1ns / 100ps
// Expected-result type and scoreboard of the ranked list testbench.
package ranked_list_bench_pkg;
  import tkcr_pkg::*;

  localparam int ListDepth = MaxEntriesDef;
  localparam int PrintCap  = 40;

  typedef struct packed {
    logic                 accepted;
    logic [PosW-1:0]      position;
    logic                 evicted_valid;
    logic [TagW-1:0]      evicted_tag;
    logic [CountOutW-1:0] entry_count;
    logic                 best_valid;
    logic [CostW-1:0]     best_cost;
    logic [TagW-1:0]      best_tag;
  } list_result_t;

  class ranked_list_scoreboard;
    logic signed [CostW-1:0] rank_cost [ListDepth];
    logic [TagW-1:0]         rank_tag [ListDepth];
    int                      held;
    logic [CfgW-1:0]         capacity;
    list_result_t            expected_results [$];
    int unsigned             errors;
    int unsigned             results_checked;
    int unsigned             kept;
    int unsigned             rejected;
    int unsigned             evictions;
    int unsigned             trims_applied;
    int                      deepest;

    function new();
      held            = 0;
      capacity        = CapacityReset;
      errors          = 0;
      results_checked = 0;
      kept            = 0;
      rejected        = 0;
      evictions       = 0;
      trims_applied   = 0;
      deepest         = 0;
    endfunction

    function void set_capacity(logic [CfgW-1:0] value);
      capacity = value;
    endfunction

    // Works out the result of one accepted input transfer and updates the list.
    function void note_item(logic cmd, logic signed [CostW-1:0] offered_cost,
                            logic [TagW-1:0] offered_tag, logic [TrimW-1:0] trim);
      list_result_t r;
      int           limit;
      int           slot;
      int           last;
      r = '0;
      if (capacity == 0) begin
        limit = 1;
      end else if (capacity > ListDepth) begin
        limit = ListDepth;
      end else begin
        limit = int'(capacity);
      end
      if (cmd == CmdInsert) begin
        // Equal costs keep the older entry ahead, hence the strict compare.
        slot = held;
        for (int i = 0; i < held; i++) begin
          if (slot == held && offered_cost > rank_cost[i]) begin
            slot = i;
          end
        end
        if (slot < held) begin
          last = held;
          if (held + 1 > limit) begin
            r.evicted_valid = 1'b1;
            r.evicted_tag   = rank_tag[held-1];
            last            = held - 1;
            evictions++;
          end
          for (int i = last; i > slot; i--) begin
            rank_cost[i] = rank_cost[i-1];
            rank_tag[i]  = rank_tag[i-1];
          end
          rank_cost[slot] = offered_cost;
          rank_tag[slot]  = offered_tag;
          held            = last + 1;
          r.accepted      = 1'b1;
          r.position      = slot[PosW-1:0];
          kept++;
        end else if (held < limit) begin
          rank_cost[held] = offered_cost;
          rank_tag[held]  = offered_tag;
          r.accepted      = 1'b1;
          r.position      = held[PosW-1:0];
          held++;
          kept++;
        end else begin
          rejected++;
        end
      end else if (held > int'(trim)) begin
        held -= int'(trim);
        trims_applied++;
      end
      if (held > deepest) begin
        deepest = held;
      end
      r.entry_count = held[CountOutW-1:0];
      if (held > 0) begin
        r.best_valid = 1'b1;
        r.best_cost  = rank_cost[0];
        r.best_tag   = rank_tag[0];
      end
      expected_results = {expected_results, r};
    endfunction

    task report_failure(string note);
      if (errors < PrintCap) begin
        $display("%0t: %s", $time, note);
      end
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_failure($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 results_checked, name, got, want));
      end
    endtask

    task check_result(list_result_t seen);
      list_result_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result %0d arrived with no item waiting for it",
                                 results_checked));
        return;
      end
      want = expected_results.pop_front();
      compare_field("accepted", 32'(seen.accepted), 32'(want.accepted));
      compare_field("position", 32'(seen.position), 32'(want.position));
      compare_field("evicted_valid", 32'(seen.evicted_valid), 32'(want.evicted_valid));
      compare_field("evicted_tag", 32'(seen.evicted_tag), 32'(want.evicted_tag));
      compare_field("entry_count", 32'(seen.entry_count), 32'(want.entry_count));
      compare_field("best_valid", 32'(seen.best_valid), 32'(want.best_valid));
      compare_field("best_cost", seen.best_cost, want.best_cost);
      compare_field("best_tag", 32'(seen.best_tag), 32'(want.best_tag));
    endtask
  endclass

endpackage

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the top-k cost ranked list unit.
module testbench;
  import tkcr_pkg::*;
  import ranked_list_bench_pkg::*;

  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned PhaseItems   = 70;
  localparam int unsigned PhaseCount   = 10;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgW-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    command;
  logic signed [CostW-1:0] cost;
  logic [TagW-1:0]         tag;
  logic [TrimW-1:0]        trim_count;
  logic                    out_valid;
  logic                    out_ready;
  logic                    accepted;
  logic [PosW-1:0]         position;
  logic                    evicted_valid;
  logic [TagW-1:0]         evicted_tag;
  logic [CountOutW-1:0]    entry_count;
  logic                    best_valid;
  logic signed [CostW-1:0] best_cost;
  logic [TagW-1:0]         best_tag;

  ranked_list_scoreboard list_tracker;
  int unsigned           sent_items;
  int unsigned           taken_items;
  int unsigned           quiet_cycles;
  logic                  sender_eager;
  logic                  long_hold_pending;

  top_k_cost_ranked_list_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .cost_i         (cost),
    .tag_i          (tag),
    .trim_count_i   (trim_count),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .accepted_o     (accepted),
    .position_o     (position),
    .evicted_valid_o(evicted_valid),
    .evicted_tag_o  (evicted_tag),
    .entry_count_o  (entry_count),
    .best_valid_o   (best_valid),
    .best_cost_o    (best_cost),
    .best_tag_o     (best_tag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every fourth run of 32 items goes without any idling on that side.
  function automatic int unsigned idle_gap(int unsigned n);
    if ((n / 32) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_item(input logic cmd, input logic signed [CostW-1:0] c,
                           input logic [TagW-1:0] t, input logic [TrimW-1:0] n);
    int unsigned gap;
    gap = sender_eager ? 0 : idle_gap(sent_items);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    cost       <= c;
    tag        <= t;
    trim_count <= n;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_random_item();
    logic                    cmd;
    logic signed [CostW-1:0] c;
    logic [TagW-1:0]         t;
    logic [TrimW-1:0]        n;
    int unsigned             pick;
    cmd  = ($urandom_range(0, 99) < 85) ? CmdInsert : CmdTrim;
    pick = $urandom_range(0, 9);
    // A narrow band of small costs makes equal costs common.
    if (pick < 5) begin
      c = int'($urandom_range(0, 12)) - 6;
    end else if (pick == 5) begin
      c = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    end else begin
      c = $urandom();
    end
    t    = TagW'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      n = TrimW'($urandom_range(0, 3));
    end else if (pick < 9) begin
      n = TrimW'($urandom_range(0, 40));
    end else begin
      n = TrimW'($urandom_range(0, 63));
    end
    send_item(cmd, c, t, n);
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (list_tracker.expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] phase_caps [PhaseCount];
    list_tracker      = new();
    sent_items        = 0;
    sender_eager      = 1'b0;
    long_hold_pending = 1'b0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    command           = CmdInsert;
    cost              = '0;
    tag               = '0;
    trim_count        = '0;
    phase_caps = '{6'd63, 6'd32, 6'd3, 6'd0, 6'd33, 6'd1, 6'd2, 6'd17, 6'd40, 6'd8};
    phase_caps[PhaseCount-1] = CfgW'($urandom_range(0, 63));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the capacity left by reset.
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd0);
    send_item(CmdInsert, 32'sd0,          8'h00, 6'd0);
    send_item(CmdInsert, 32'sh7ffffffe,   8'hff, 6'd0);
    send_item(CmdInsert, 32'sh80000000,   8'h01, 6'd0);
    send_item(CmdInsert, 32'sd0,          8'h02, 6'd0);
    send_item(CmdInsert, -32'sd1,         8'haa, 6'd0);
    send_item(CmdInsert, 32'sd1,          8'h55, 6'd0);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd6);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd63);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd4);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd1);
    send_item(CmdInsert, -32'sd2147483647, 8'h80, 6'd0);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd32);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd1);
    drain_results();
    write_capacity(6'd1);
    send_item(CmdInsert, 32'sh80000000,   8'h12, 6'd0);
    send_item(CmdInsert, 32'sh7ffffffe,   8'h13, 6'd0);
    send_item(CmdInsert, 32'sh7fffffff,   8'h11, 6'd0);
    drain_results();
    write_capacity(6'd0);
    send_item(CmdInsert, 32'sh7fffffff,   8'h21, 6'd0);
    send_item(CmdTrim,   32'sd0,          8'h00, 6'd0);
    send_item(CmdInsert, 32'sh80000000,   8'h22, 6'd0);
    drain_results();

    // Random part: one capacity per phase, the list carried across phases so
    // that a lowered capacity finds more entries than it allows.
    for (int p = 0; p < PhaseCount; p++) begin
      write_capacity(phase_caps[p]);
      if (p == 1) begin
        long_hold_pending = 1'b1;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        sender_eager = (p == 1 && k < 24);
        send_random_item();
      end
      sender_eager = 1'b0;
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d items at capacities 0 to 63: %0d kept, %0d rejected, %0d evicted,",
             sent_items, list_tracker.kept, list_tracker.rejected, list_tracker.evictions);
    $display("%0d trims applied, lists up to %0d entries, %0d results checked, %0d mismatches.",
             list_tracker.trims_applied, list_tracker.deepest,
             list_tracker.results_checked, list_tracker.errors);
    if (list_tracker.errors == 0 && list_tracker.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // The receiver draws a stall before each result; once it holds off for a
  // long stretch so that the unit fills up and refuses further transfers.
  initial begin : receiver
    int unsigned gap;
    logic        hold_used;
    taken_items = 0;
    hold_used   = 1'b0;
    out_ready   = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = idle_gap(taken_items);
      if (long_hold_pending && !hold_used) begin
        gap       = LongHold;
        hold_used = 1'b1;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken_items++;
    end
  end

  always @(posedge clk) begin : transfer_monitor
    list_result_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        list_tracker.set_capacity(cfg_data);
      end
      if (in_valid && in_ready) begin
        list_tracker.note_item(command, cost, tag, trim_count);
      end
      if (out_valid && out_ready) begin
        seen.accepted      = accepted;
        seen.position      = position;
        seen.evicted_valid = evicted_valid;
        seen.evicted_tag   = evicted_tag;
        seen.entry_count   = entry_count;
        seen.best_valid    = best_valid;
        seen.best_cost     = best_cost;
        seen.best_tag      = best_tag;
        list_tracker.check_result(seen);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
